/* design/touch_key_baseline_detector_defines.svh */
// ----------------------------------------------------------------------------
// Touch key baseline detector assertion macros
// Shared concurrent assertion forms; expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef TOUCH_KEY_BASELINE_DETECTOR_DEFINES_SVH
`define TOUCH_KEY_BASELINE_DETECTOR_DEFINES_SVH

// cond must hold at every clock edge out of reset
`define TKBD_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// ante at one edge implies cons at the next
`define TKBD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// ante implies cons at the same edge
`define TKBD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* design/tkbd_pkg.sv */
// ----------------------------------------------------------------------------
// Touch key baseline detector package
// Widths, register indexes, key label table and the per-key update record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tkbd_pkg;

    localparam int NUM_KEYS  = 12;
    localparam int KEY_IDX_W = $clog2(NUM_KEYS);

    localparam int KEY_W    = 4;
    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 16;
    localparam int CNT_W    = 7;
    localparam int CHAR_W   = 7;
    localparam int CFG_W    = 7;
    localparam int CFG_IDX_W = 1;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_CONFIRM = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD    = 1'd1;

    localparam logic [CFG_W-1:0] CONFIRM_RESET = 7'd2;
    localparam logic [CFG_W-1:0] HOLD_RESET    = 7'd100;
    localparam logic [CNT_W-1:0] COUNT_MAX     = 7'd127;

    localparam logic REQ_CAL = 1'b0;
    localparam logic REQ_DET = 1'b1;

    typedef struct packed {
        logic             wr;
        logic [SUM_W-1:0] baseline;
        logic [CNT_W-1:0] count;
        logic             hit;
    } upd_t;

    function automatic logic [CHAR_W-1:0] key_label(input logic [KEY_W-1:0] key);
        logic [CHAR_W-1:0] ch;
        case (key)
            4'd0:    ch = 7'h30; // '0'
            4'd1:    ch = 7'h42; // 'B'
            4'd2:    ch = 7'h39; // '9'
            4'd3:    ch = 7'h36; // '6'
            4'd4:    ch = 7'h43; // 'C'
            4'd5:    ch = 7'h38; // '8'
            4'd6:    ch = 7'h35; // '5'
            4'd7:    ch = 7'h33; // '3'
            4'd8:    ch = 7'h37; // '7'
            4'd9:    ch = 7'h34; // '4'
            4'd10:   ch = 7'h31; // '1'
            4'd11:   ch = 7'h32; // '2'
            default: ch = 7'h2E; // '.'
        endcase
        return ch;
    endfunction

endpackage

/* design/tkbd_eval.sv */
// ----------------------------------------------------------------------------
// Touch key baseline detector evaluation
// Thresholds, press counting and baseline tracking for one sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tkbd_eval
(
    input  logic                          in_range,
    input  logic                          req_type,
    input  logic [tkbd_pkg::SAMPLE_W-1:0] sample,
    input  logic [tkbd_pkg::SUM_W-1:0]    baseline,
    input  logic [tkbd_pkg::CNT_W-1:0]    count,
    input  logic [tkbd_pkg::CFG_W-1:0]    confirm_count,
    input  logic [tkbd_pkg::CFG_W-1:0]    hold_limit,
    output tkbd_pkg::upd_t                upd
);

    logic [tkbd_pkg::SUM_W-1:0] press_th;
    logic [tkbd_pkg::SUM_W-1:0] release_th;
    logic [tkbd_pkg::SUM_W-1:0] tracked;
    logic [tkbd_pkg::CNT_W-1:0] bumped;
    logic                       cnt_zero;
    logic [tkbd_pkg::SUM_W-1:0] b_new;
    logic [tkbd_pkg::CNT_W-1:0] c_new;

    assign press_th   = (baseline >> 4) - (baseline >> 9);
    assign release_th = (baseline >> 4) - (baseline >> 10);
    assign tracked    = baseline + sample - (baseline >> 4);
    assign bumped     = (count >= tkbd_pkg::COUNT_MAX) ? tkbd_pkg::COUNT_MAX
                                                       : count + 7'd1;
    assign cnt_zero   = (count == '0);

    always_comb
    begin
        b_new = baseline;
        c_new = count;
        if (req_type == tkbd_pkg::REQ_CAL)
        begin
            b_new = baseline + sample;
            c_new = '0;
        end
        else if (!cnt_zero && (sample < release_th))
        begin
            if (count > hold_limit)
                b_new = tracked;
            else
                c_new = bumped;
        end
        else if (cnt_zero && (sample < press_th))
        begin
            c_new = 7'd1;
        end
        else
        begin
            c_new = '0;
            b_new = tracked;
        end
    end

    assign upd.wr       = in_range;
    assign upd.baseline = b_new;
    assign upd.count    = c_new;
    assign upd.hit      = in_range && (req_type == tkbd_pkg::REQ_DET)
                          && (c_new == confirm_count);

endmodule

/* design/touch_key_baseline_detector.sv */
// ----------------------------------------------------------------------------
// Touch key baseline detector
// Takes one key sample per cycle and reports a key once its press count
// reaches confirm_count. Each item is registered on input, evaluated against
// the key's baseline held in flip-flops, and its result lands in an output
// register, and one item is accepted every cycle while input is not stalled;
// the baseline and count writes complete in the evaluation cycle, so a
// following item for the same key sees them. Input stalls only while a
// result waits in the output register and the item in evaluation makes one.
// Keys at or above NUM_KEYS are dropped. Registers: 0 confirm_count,
// 1 hold_limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module touch_key_baseline_detector
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_wr_en,
    input  logic [tkbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tkbd_pkg::CFG_W-1:0]      cfg_wdata,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tkbd_pkg::IN_DATA_W-1:0]  s_tdata,  // key_index[3:0], sample[19:4]
    input  logic                            s_tuser,  // req_type

    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tkbd_pkg::OUT_DATA_W-1:0] m_tdata   // key_index_res[3:0], key_char[10:4]
);

    logic [tkbd_pkg::CFG_W-1:0] confirm_reg;
    logic [tkbd_pkg::CFG_W-1:0] hold_reg;

    logic [tkbd_pkg::SUM_W-1:0] baseline_reg [tkbd_pkg::NUM_KEYS];
    logic [tkbd_pkg::CNT_W-1:0] count_reg    [tkbd_pkg::NUM_KEYS];

    logic                          in_valid_reg;
    logic                          in_type_reg;
    logic [tkbd_pkg::KEY_W-1:0]    in_key_reg;
    logic [tkbd_pkg::SAMPLE_W-1:0] in_sample_reg;

    logic                          out_valid_reg;
    logic [tkbd_pkg::KEY_W-1:0]    out_key_reg;
    logic [tkbd_pkg::CHAR_W-1:0]   out_char_reg;

    logic                          in_range;
    logic [tkbd_pkg::KEY_IDX_W-1:0] idx;
    tkbd_pkg::upd_t                upd;
    logic                          eval_go;
    logic                          take;

    // config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            confirm_reg <= tkbd_pkg::CONFIRM_RESET;
            hold_reg    <= tkbd_pkg::HOLD_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                tkbd_pkg::REG_CONFIRM: confirm_reg <= cfg_wdata;
                tkbd_pkg::REG_HOLD:    hold_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign in_range = (32'(in_key_reg) < tkbd_pkg::NUM_KEYS);
    assign idx      = in_range ? in_key_reg[tkbd_pkg::KEY_IDX_W-1:0] : '0;

    tkbd_eval u_eval
    (
        .in_range      (in_range),
        .req_type      (in_type_reg),
        .sample        (in_sample_reg),
        .baseline      (baseline_reg[idx]),
        .count         (count_reg[idx]),
        .confirm_count (confirm_reg),
        .hold_limit    (hold_reg),
        .upd           (upd)
    );

    assign eval_go  = in_valid_reg && (!upd.hit || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || eval_go;
    assign take     = s_tvalid && s_tready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_type_reg   <= s_tuser;
            in_key_reg    <= s_tdata[tkbd_pkg::KEY_W-1:0];
            in_sample_reg <= s_tdata[tkbd_pkg::KEY_W +: tkbd_pkg::SAMPLE_W];
        end
    end

    // per-key state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tkbd_pkg::NUM_KEYS; i++)
            begin
                baseline_reg[i] <= '0;
                count_reg[i]    <= '0;
            end
        end
        else if (eval_go && upd.wr)
        begin
            baseline_reg[idx] <= upd.baseline;
            count_reg[idx]    <= upd.count;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (eval_go && upd.hit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (eval_go && upd.hit)
        begin
            out_key_reg  <= in_key_reg;
            out_char_reg <= tkbd_pkg::key_label(in_key_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_char_reg, out_key_reg};

endmodule

/* design/tkbd_checker.sv */
// ----------------------------------------------------------------------------
// Touch key baseline detector checker
// Port-level assertions on the result stream and input handshake, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "touch_key_baseline_detector_defines.svh"

module tkbd_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [tkbd_pkg::OUT_DATA_W-1:0] m_tdata
);

    `TKBD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    `TKBD_ASSERT_SAME(a_key_range, m_tvalid, m_tdata[3:0] < 4'd12 && m_tdata[15:11] == 5'd0, "result key out of range")

    `TKBD_ASSERT_SAME(a_label_b, m_tvalid && m_tdata[3:0] == 4'd1, m_tdata[10:4] == 7'h42, "key 1 label mismatch")

    `TKBD_ASSERT_SAME(a_latency, $rose(m_tvalid), $past(s_tvalid && s_tready, 2), "result without accepted item two cycles earlier")

endmodule

bind touch_key_baseline_detector tkbd_checker u_tkbd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch key baseline detector testbench
// Streams calibration and detection samples into the detector and checks
// every touch result against a cycle-free model of the per-key baseline
// and press count. A short table of directed items comes first. Random
// press and release runs follow, built from the model's current thresholds,
// under several register settings. Both stream sides idle at random, and
// the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------

module testbench;

    localparam int QUIET_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 100;
    localparam int DIR_ROWS        = 23;

    // key labels, key 0 in the highest byte
    localparam logic [16*8-1:0] KEY_LABELS = "0B96C8537412....";

    typedef enum logic [1:0] {BY_MODEL, NO_TOUCH, TOUCH} chk_t;

    typedef struct packed {
        logic                          req;
        logic [tkbd_pkg::KEY_W-1:0]    key;
        logic [tkbd_pkg::SAMPLE_W-1:0] smp;
        chk_t                          chk;
        logic [tkbd_pkg::CHAR_W-1:0]   ch;
    } stim_row_t;

    typedef struct packed {
        logic [tkbd_pkg::KEY_W-1:0]  key;
        logic [tkbd_pkg::CHAR_W-1:0] ch;
    } touch_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_wr_en;
    logic [tkbd_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [tkbd_pkg::CFG_W-1:0]      cfg_wdata;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [tkbd_pkg::IN_DATA_W-1:0]  s_tdata;   // key_index[3:0], sample[19:4]
    logic                            s_tuser;   // req_type
    logic                            m_tvalid;
    logic                            m_tready;
    logic [tkbd_pkg::OUT_DATA_W-1:0] m_tdata;   // key_index_res[3:0], key_char[10:4]

    logic [tkbd_pkg::SUM_W-1:0]      base_sum [tkbd_pkg::NUM_KEYS];
    logic [tkbd_pkg::CNT_W-1:0]      press_cnt [tkbd_pkg::NUM_KEYS];
    logic [tkbd_pkg::CFG_W-1:0]      confirm_reg;
    logic [tkbd_pkg::CFG_W-1:0]      hold_reg;
    touch_t                          touch_q [$];
    touch_t                          exp_ev;
    int                              fail_cnt   = 0;
    int                              fed_cnt    = 0;
    int                              quiet_cyc  = 0;
    bit                              tx_idle_on = 1'b0;
    bit                              rx_idle_on = 1'b0;
    bit                              hold_req   = 1'b0;

    stim_row_t dir_rows [DIR_ROWS] = '{
        '{tkbd_pkg::REQ_DET, 4'd0,  16'h0000, NO_TOUCH, 7'h00},
        '{tkbd_pkg::REQ_DET, 4'd11, 16'hFFFF, NO_TOUCH, 7'h00},
        '{tkbd_pkg::REQ_CAL, 4'd15, 16'h04D2, NO_TOUCH, 7'h00},
        '{tkbd_pkg::REQ_DET, 4'd12, 16'h0000, NO_TOUCH, 7'h00},
        '{tkbd_pkg::REQ_DET, 4'd15, 16'h0000, NO_TOUCH, 7'h00},
        '{tkbd_pkg::REQ_CAL, 4'd0,  16'd16000, NO_TOUCH, 7'h00},
        '{tkbd_pkg::REQ_DET, 4'd0,  16'h0000, BY_MODEL, 7'h00},
        '{tkbd_pkg::REQ_DET, 4'd0,  16'h0000, TOUCH,    7'h30},
        '{tkbd_pkg::REQ_DET, 4'd0,  16'h0000, BY_MODEL, 7'h00},
        '{tkbd_pkg::REQ_DET, 4'd0,  16'hFFFF, BY_MODEL, 7'h00},
        '{tkbd_pkg::REQ_CAL, 4'd11, 16'hFFFF, NO_TOUCH, 7'h00},
        '{tkbd_pkg::REQ_CAL, 4'd11, 16'hFFFF, NO_TOUCH, 7'h00},
        '{tkbd_pkg::REQ_DET, 4'd11, 16'h0000, BY_MODEL, 7'h00},
        '{tkbd_pkg::REQ_DET, 4'd11, 16'h0000, TOUCH,    7'h32},
        '{tkbd_pkg::REQ_DET, 4'd11, 16'd4000, BY_MODEL, 7'h00},
        '{tkbd_pkg::REQ_DET, 4'd11, 16'd4050, BY_MODEL, 7'h00},
        '{tkbd_pkg::REQ_CAL, 4'd7,  16'h8000, NO_TOUCH, 7'h00},
        '{tkbd_pkg::REQ_DET, 4'd7,  16'h0800, BY_MODEL, 7'h00},
        '{tkbd_pkg::REQ_DET, 4'd7,  16'h0001, BY_MODEL, 7'h00},
        '{tkbd_pkg::REQ_DET, 4'd7,  16'h0001, BY_MODEL, 7'h00},
        '{tkbd_pkg::REQ_DET, 4'd5,  16'hAAAA, BY_MODEL, 7'h00},
        '{tkbd_pkg::REQ_CAL, 4'd10, 16'h5555, NO_TOUCH, 7'h00},
        '{tkbd_pkg::REQ_DET, 4'd14, 16'hFFFF, NO_TOUCH, 7'h00}
    };

    touch_key_baseline_detector u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [tkbd_pkg::SUM_W-1:0] press_level(
        input logic [tkbd_pkg::SUM_W-1:0] b);
        return (b >> 4) - (b >> 9);
    endfunction

    function automatic logic [tkbd_pkg::SUM_W-1:0] release_level(
        input logic [tkbd_pkg::SUM_W-1:0] b);
        return (b >> 4) - (b >> 10);
    endfunction

    // updates the key state and returns 1 when the item confirms a touch
    function automatic logic judge_sample(input logic req,
                                          input logic [tkbd_pkg::KEY_W-1:0] key,
                                          input logic [tkbd_pkg::SAMPLE_W-1:0] smp);
        logic [tkbd_pkg::SUM_W-1:0] b;
        logic [tkbd_pkg::CNT_W-1:0] c;
        if (key >= tkbd_pkg::NUM_KEYS)
            return 1'b0;
        if (req == tkbd_pkg::REQ_CAL)
        begin
            base_sum[key]  = base_sum[key] + smp;
            press_cnt[key] = '0;
            return 1'b0;
        end
        b = base_sum[key];
        c = press_cnt[key];
        if (c != 0 && smp < release_level(b))
        begin
            if (c > hold_reg)
                b = b + smp - (b >> 4);
            else if (c != tkbd_pkg::COUNT_MAX)
                c = c + 1'b1;
        end
        else if (c == 0 && smp < press_level(b))
            c = tkbd_pkg::CNT_W'(1);
        else
        begin
            c = '0;
            b = b + smp - (b >> 4);
        end
        base_sum[key]  = b;
        press_cnt[key] = c;
        return c == confirm_reg;
    endfunction

    task automatic send_item(input logic req, input logic [tkbd_pkg::KEY_W-1:0] key,
                             input logic [tkbd_pkg::SAMPLE_W-1:0] smp, input chk_t chk,
                             input logic [tkbd_pkg::CHAR_W-1:0] ch);
        logic   hit;
        touch_t ev;
        if (tx_idle_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {{(tkbd_pkg::IN_DATA_W - tkbd_pkg::KEY_W - tkbd_pkg::SAMPLE_W){1'b0}},
                     smp, key};
        do
            @(posedge clk);
        while (!s_tready);
        hit = judge_sample(req, key, smp);
        if (key < tkbd_pkg::NUM_KEYS)
            fed_cnt++;
        ev.key = key;
        ev.ch  = (chk == TOUCH) ? ch
                                : KEY_LABELS[(15 - int'(key)) * 8 +: tkbd_pkg::CHAR_W];
        if (chk == TOUCH || (chk == BY_MODEL && hit))
            touch_q.push_back(ev);
        @(negedge clk);
    endtask

    task automatic run_phase(input logic [tkbd_pkg::CFG_W-1:0] conf,
                             input logic [tkbd_pkg::CFG_W-1:0] hold,
                             input int n_items, input bit idle, input bit pressure,
                             input bit long_first);
        int                            start;
        int                            lim;
        int                            len;
        int                            r;
        bit                            first;
        logic [tkbd_pkg::KEY_W-1:0]    k;
        logic [tkbd_pkg::SAMPLE_W-1:0] smp;
        logic [tkbd_pkg::SAMPLE_W-1:0] pth;
        logic [tkbd_pkg::SAMPLE_W-1:0] rth;
        logic [tkbd_pkg::SAMPLE_W-1:0] top;
        s_tvalid <= 1'b0;
        while (touch_q.size() != 0)
            @(negedge clk);
        // let a trailing item with no result clear the pipeline
        repeat (4) @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= tkbd_pkg::REG_CONFIRM;
        cfg_wdata <= conf;
        @(negedge clk);
        cfg_index <= tkbd_pkg::REG_HOLD;
        cfg_wdata <= hold;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        confirm_reg = conf;
        hold_reg    = hold;
        tx_idle_on  = idle;
        rx_idle_on  = idle;
        hold_req    = pressure;
        lim = ((conf > hold) ? int'(conf) : int'(hold)) + 4;
        if (lim > 135)
            lim = 135;
        first = long_first;
        start = fed_cnt;
        while (fed_cnt - start < n_items)
        begin
            r = $urandom_range(0, 99);
            k = tkbd_pkg::KEY_W'($urandom_range(0, tkbd_pkg::NUM_KEYS - 1));
            if (r < 8)
            begin
                if ($urandom_range(0, 3) == 0)
                    smp = tkbd_pkg::SAMPLE_W'($urandom_range(0, 65535));
                else
                    smp = tkbd_pkg::SAMPLE_W'($urandom_range(0, 4095));
                send_item(tkbd_pkg::REQ_CAL, k, smp, BY_MODEL, '0);
            end
            else if (r < 14)
                send_item(1'($urandom_range(0, 1)),
                          tkbd_pkg::KEY_W'($urandom_range(0, 15)),
                          tkbd_pkg::SAMPLE_W'($urandom_range(0, 65535)), BY_MODEL, '0);
            else
            begin
                // press run: a baseline first if there is none, then held
                // samples, then release samples
                if (base_sum[k] < 16'd256)
                    send_item(tkbd_pkg::REQ_CAL, k,
                              tkbd_pkg::SAMPLE_W'($urandom_range(8000, 30000)),
                              BY_MODEL, '0);
                case ($urandom_range(0, 3))
                    0:       len = lim;
                    1:       len = $urandom_range(1, lim);
                    default: len = $urandom_range(1, 6);
                endcase
                if (first)
                begin
                    len   = lim;
                    first = 1'b0;
                end
                repeat (len)
                begin
                    pth = press_level(base_sum[k]);
                    rth = release_level(base_sum[k]);
                    top = (press_cnt[k] == 0) ? pth : rth;
                    if (rth > pth && $urandom_range(0, 7) == 0)
                        smp = tkbd_pkg::SAMPLE_W'($urandom_range(pth, rth - 1'b1));
                    else if (top == 0)
                        smp = '0;
                    else
                        smp = tkbd_pkg::SAMPLE_W'($urandom_range(0, top - 1'b1));
                    send_item(tkbd_pkg::REQ_DET, k, smp, BY_MODEL, '0);
                end
                repeat ($urandom_range(1, 3))
                begin
                    rth = release_level(base_sum[k]);
                    if ($urandom_range(0, 9) == 0)
                        smp = tkbd_pkg::SAMPLE_W'($urandom_range(0, 65535));
                    else if (rth > 16'hFEC0)
                        smp = 16'hFFFF;
                    else
                        smp = rth + tkbd_pkg::SAMPLE_W'($urandom_range(0, 300));
                    send_item(tkbd_pkg::REQ_DET, k, smp, BY_MODEL, '0);
                end
            end
        end
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                m_tready <= 1'b1;
            end
            else if (rx_idle_on && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (touch_q.size() == 0)
            begin
                $display("%0t: unexpected touch, expected none, actual key %0d char 0x%02h",
                         $time, m_tdata[tkbd_pkg::KEY_W-1:0],
                         m_tdata[tkbd_pkg::KEY_W +: tkbd_pkg::CHAR_W]);
                fail_cnt++;
            end
            else
            begin
                exp_ev = touch_q.pop_front();
                if (m_tdata[tkbd_pkg::KEY_W-1:0] !== exp_ev.key)
                begin
                    $display("%0t: key_index_res mismatch, expected %0d, actual %0d",
                             $time, exp_ev.key, m_tdata[tkbd_pkg::KEY_W-1:0]);
                    fail_cnt++;
                end
                if (m_tdata[tkbd_pkg::KEY_W +: tkbd_pkg::CHAR_W] !== exp_ev.ch)
                begin
                    $display("%0t: key_char mismatch, expected 0x%02h, actual 0x%02h",
                             $time, exp_ev.ch, m_tdata[tkbd_pkg::KEY_W +: tkbd_pkg::CHAR_W]);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cyc = 0;
        else
            quiet_cyc = quiet_cyc + 1;
        if (quiet_cyc >= QUIET_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles, %0d touches outstanding",
                     $time, QUIET_LIMIT, touch_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        for (int i = 0; i < tkbd_pkg::NUM_KEYS; i++)
        begin
            base_sum[i]  = '0;
            press_cnt[i] = '0;
        end
        confirm_reg = tkbd_pkg::CONFIRM_RESET;
        hold_reg    = tkbd_pkg::HOLD_RESET;
        repeat (7) @(negedge clk);
        rst_n      = 1'b1;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        @(negedge clk);
        for (int i = 0; i < DIR_ROWS; i++)
            send_item(dir_rows[i].req, dir_rows[i].key, dir_rows[i].smp,
                      dir_rows[i].chk, dir_rows[i].ch);
        run_phase(7'd2,   7'd100, 200, 1'b1, 1'b0, 1'b0);
        run_phase(7'd1,   7'd1,   180, 1'b1, 1'b1, 1'b0);
        run_phase(7'd126, 7'd126, 170, 1'b1, 1'b0, 1'b0);
        // confirm at zero, count free to saturate
        run_phase(7'd0,   7'd127, 150, 1'b1, 1'b0, 1'b1);
        run_phase(7'd3,   7'd5,   120, 1'b1, 1'b0, 1'b0);
        run_phase(7'd7,   7'd20,  70,  1'b0, 1'b0, 1'b0);
        s_tvalid <= 1'b0;
        while (touch_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
